/* rtl/core/direct_mapped_cache_with_side_buffer_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the direct-mapped cache with side buffer
// Shared immediate-implication and next-cycle forms used by the core modules.
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_CACHE_WITH_SIDE_BUFFER_DEFINES_SVH
`define DIRECT_MAPPED_CACHE_WITH_SIDE_BUFFER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMCSB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DMCSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/dmcsb_pkg.sv */
// ----------------------------------------------------------------------------
// dmcsb_pkg
// Types, codes and helper functions shared by the cache model modules.
// ----------------------------------------------------------------------------
package dmcsb_pkg;

   localparam int MODE_W  = 2;
   localparam int BSL_W   = 4;
   localparam int CSL_W   = 5;
   localparam int KIND_W  = 2;
   localparam int CNT_W   = 32;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   localparam logic [MODE_W-1:0] MODE_PLAIN  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_VICTIM = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STREAM = 2'd2;

   localparam logic [KIND_W-1:0] KIND_MISS   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LINE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BUFFER = 2'd2;

   localparam logic [1:0] CSR_MODE  = 2'd0;
   localparam logic [1:0] CSR_BLOCK = 2'd1;
   localparam logic [1:0] CSR_CACHE = 2'd2;

   localparam logic [MODE_W-1:0] MODE_RESET = MODE_PLAIN;
   localparam logic [BSL_W-1:0]  BSL_RESET  = 4'd5;
   localparam logic [CSL_W-1:0]  CSL_RESET  = 5'd15;

   localparam logic [CNT_W-1:0] TIME_LINE   = 32'd1;
   localparam logic [CNT_W-1:0] TIME_BUFFER = 32'd6;
   localparam logic [CNT_W-1:0] TIME_MISS   = 32'd100;

   typedef struct packed {
      logic load;
      logic mul_lo;
      logic mul_hi;
      logic read;
      logic update;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } sts_type;

   typedef struct packed {
      logic [CNT_W-1:0]  time_total;
      logic [CNT_W-1:0]  miss_total;
      logic [CNT_W-1:0]  access_total;
      logic [KIND_W-1:0] hit_kind;
   } rsp_type;

   localparam int RSP_BITS    = $bits(rsp_type);
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   function automatic logic is_pow2(input int n);
      return ((n & (n - 1)) == 0);
   endfunction

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? '1 : s[CNT_W-1:0];
   endfunction

endpackage

/* rtl/core/dmcsb_ram.sv */
// ----------------------------------------------------------------------------
// dmcsb_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module dmcsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/dmcsb_ctrl.sv */
// ----------------------------------------------------------------------------
// dmcsb_ctrl
// Sequencer for the tag store clearing pass, index reduction, tag read and
// update, and the result handshake.
// ----------------------------------------------------------------------------
`include "direct_mapped_cache_with_side_buffer_defines.svh"

module dmcsb_ctrl #(
   parameter bit SHORT_INDEX = 1'b1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output dmcsb_pkg::cmd_type cmd,
   input  dmcsb_pkg::sts_type sts
);

   import dmcsb_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_READ,
      ST_LOOKUP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;
   state_type start_state;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign start_state = SHORT_INDEX ? ST_READ : ST_MUL_LO;
   assign req_tready  = (state_ff == ST_IDLE) || ((state_ff == ST_LOOKUP) && out_free);
   assign accept      = req_tvalid && req_tready;
   assign rsp_tvalid  = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.load       = accept;
      cmd.mul_lo     = (state_ff == ST_MUL_LO);
      cmd.mul_hi     = (state_ff == ST_MUL_HI);
      cmd.read       = (state_ff == ST_READ);
      cmd.update     = (state_ff == ST_LOOKUP) && out_free;
      cmd.clear_step = (state_ff == ST_CLEAR);
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = start_state;
            end
         end
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_READ;
         ST_READ:   state_in = ST_LOOKUP;
         ST_LOOKUP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = accept ? start_state : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `DMCSB_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_tready,
      !cmd.update, "result overwritten while still pending")
   `DMCSB_ASSERT_NOW(a_no_accept_clear, clock, reset, state_ff == ST_CLEAR,
      !req_tready, "item accepted during the clearing pass")
   `DMCSB_ASSERT_NEXT(a_update_shows, clock, reset, cmd.update,
      rsp_valid_ff, "update did not present a result")

endmodule

/* rtl/core/dmcsb_dp.sv */
// ----------------------------------------------------------------------------
// dmcsb_dp
// Datapath: configuration registers, index reduction, tag store, side buffer
// and the saturating counters that form the result.
// ----------------------------------------------------------------------------
`include "direct_mapped_cache_with_side_buffer_defines.svh"

module dmcsb_dp #(
   parameter int LINE_COUNT    = 1024,
   parameter int BUFFER_DEPTH  = 6,
   parameter int ADDRESS_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dmcsb_pkg::cmd_type                cmd,
   output dmcsb_pkg::sts_type                sts,
   input  logic [ADDRESS_WIDTH-1:0]          address,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dmcsb_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [dmcsb_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [dmcsb_pkg::CSR_DW-1:0]      csr_prdata,
   output dmcsb_pkg::rsp_type                rsp
);

   import dmcsb_pkg::*;

   localparam int AW = ADDRESS_WIDTH;
   localparam int XW = (AW < 31) ? AW : 31;
   localparam int LW = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
   localparam int D  = BUFFER_DEPTH;
   localparam int FW = $clog2(BUFFER_DEPTH + 1);

   logic [MODE_W-1:0] mode_ff;
   logic [BSL_W-1:0]  bsl_ff;
   logic [CSL_W-1:0]  csl_ff;
   logic              csr_wr;

   logic [AW-1:0] cmask;
   logic [AW-1:0] block_in;
   logic [AW-1:0] xs_in;
   logic [AW-1:0] block_ff;
   logic [XW-1:0] x_ff;
   logic [LW-1:0] idx_comb;
   logic [LW-1:0] idx_ff;
   logic [LW-1:0] clear_cnt_ff;

   logic          ram_we;
   logic [LW-1:0] ram_waddr;
   logic [AW:0]   ram_wdata;
   logic [AW:0]   ram_rdata;
   logic          rd_valid;
   logic [AW-1:0] rd_tag;

   logic [AW-1:0] entry_ff [D];
   logic [AW-1:0] e1 [D];
   logic [AW-1:0] e2 [D];
   logic [FW-1:0] fill_ff;
   logic [FW-1:0] f1;
   logic [FW-1:0] f2;

   logic              line_hit;
   logic              buf_hit;
   logic              take;
   logic              append;
   logic              victim_mode;
   logic              stream_mode;
   logic [AW-1:0]     app_val;
   logic [KIND_W-1:0] kind;
   logic [CNT_W-1:0]  cost;

   logic [CNT_W-1:0]  access_ff;
   logic [CNT_W-1:0]  miss_ff;
   logic [CNT_W-1:0]  time_ff;
   logic [KIND_W-1:0] kind_ff;

   // Configuration port.
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
         bsl_ff  <= BSL_RESET;
         csl_ff  <= CSL_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            CSR_MODE:  mode_ff <= csr_pwdata[MODE_W-1:0];
            CSR_BLOCK: bsl_ff  <= csr_pwdata[BSL_W-1:0];
            CSR_CACHE: csl_ff  <= csr_pwdata[CSL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         CSR_MODE:  csr_prdata = CSR_DW'(mode_ff);
         CSR_BLOCK: csr_prdata = CSR_DW'(bsl_ff);
         CSR_CACHE: csr_prdata = CSR_DW'(csl_ff);
         default:   csr_prdata = '0;
      endcase
   end

   // Block number and the line offset within the cache, taken at acceptance.
   always_comb begin
      for (int i = 0; i < AW; i++) begin
         cmask[i] = (i < int'(csl_ff));
      end
      block_in = address >> bsl_ff;
      xs_in    = (address & cmask) >> bsl_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         block_ff <= block_in;
         x_ff     <= XW'(xs_in);
      end
   end

   // Line index: the offset reduced modulo the line count.
   generate
      if (is_pow2(LINE_COUNT)) begin : g_idx_mask
         assign idx_comb = LW'(x_ff & XW'(LINE_COUNT - 1));
      end else begin : g_idx_recip
         localparam int             CW    = (XW > 17) ? XW : 17;
         localparam logic [31:0]    RECIP = 32'((64'd1 << 31) / LINE_COUNT);
         logic [XW+31:0] prod_ff;
         logic [XW-1:0]  qn_ff;
         logic [XW-1:0]  rem;
         logic [CW-1:0]  rem_ext;

         always_ff @(posedge clock) begin
            if (cmd.mul_lo) begin
               prod_ff <= (XW+32)'(x_ff) * (XW+32)'(RECIP);
            end
            if (cmd.mul_hi) begin
               qn_ff <= XW'(prod_ff[XW+30:31] * XW'(LINE_COUNT));
            end
         end

         assign rem     = x_ff - qn_ff;
         assign rem_ext = CW'(rem);
         assign idx_comb = (rem_ext >= CW'(LINE_COUNT)) ?
                           LW'(rem_ext - CW'(LINE_COUNT)) : LW'(rem_ext);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         idx_ff <= idx_comb;
      end
   end

   // Tag store with its valid bit; swept clear after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clear_cnt_ff <= clear_cnt_ff + LW'(1);
      end
   end

   assign sts.clear_last = (clear_cnt_ff == LW'(LINE_COUNT - 1));

   assign ram_we    = cmd.clear_step || (cmd.update && !line_hit);
   assign ram_waddr = cmd.clear_step ? clear_cnt_ff : idx_ff;
   assign ram_wdata = cmd.clear_step ? '0 : {1'b1, block_ff};

   dmcsb_ram #(
      .WIDTH (AW + 1),
      .DEPTH (LINE_COUNT)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.read),
      .rd_addr (idx_comb),
      .rd_data (ram_rdata)
   );

   assign rd_valid = ram_rdata[AW];
   assign rd_tag   = ram_rdata[AW-1:0];

   // Lookup, side buffer removal and append, result kind and cost.
   always_comb begin
      int nxt;
      int hit_pos;
      nxt         = 0;
      hit_pos     = 0;
      victim_mode = (mode_ff == MODE_VICTIM);
      stream_mode = (mode_ff == MODE_STREAM);
      line_hit    = rd_valid && (rd_tag == block_ff);

      buf_hit = 1'b0;
      for (int i = 0; i < D; i++) begin
         if (!buf_hit && (FW'(i) < fill_ff) && (entry_ff[i] == block_ff)) begin
            buf_hit = 1'b1;
            hit_pos = i;
         end
      end

      take = !line_hit && (victim_mode || stream_mode) && buf_hit;
      for (int i = 0; i < D; i++) begin
         nxt   = (i < D - 1) ? i + 1 : i;
         e1[i] = (take && (i >= hit_pos)) ? entry_ff[nxt] : entry_ff[i];
      end
      f1 = take ? fill_ff - FW'(1) : fill_ff;

      append  = !line_hit && ((victim_mode && rd_valid) || stream_mode);
      app_val = stream_mode ? block_ff + AW'(1) : rd_tag;
      f2      = f1;
      for (int i = 0; i < D; i++) begin
         e2[i] = e1[i];
      end
      if (append) begin
         if (f1 == FW'(D)) begin
            for (int i = 0; i < D; i++) begin
               nxt   = (i < D - 1) ? i + 1 : i;
               e2[i] = (i == D - 1) ? app_val : e1[nxt];
            end
         end else begin
            for (int i = 0; i < D; i++) begin
               if (FW'(i) == f1) begin
                  e2[i] = app_val;
               end
            end
            f2 = f1 + FW'(1);
         end
      end

      if (line_hit) begin
         kind = KIND_LINE;
      end else if (take) begin
         kind = KIND_BUFFER;
      end else begin
         kind = KIND_MISS;
      end

      case (kind)
         KIND_LINE:   cost = TIME_LINE;
         KIND_BUFFER: cost = TIME_BUFFER;
         default:     cost = TIME_MISS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         for (int i = 0; i < D; i++) begin
            entry_ff[i] <= e2[i];
         end
         kind_ff <= kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         access_ff <= '0;
         miss_ff   <= '0;
         time_ff   <= '0;
      end else if (cmd.update) begin
         fill_ff   <= f2;
         access_ff <= sat_add(access_ff, CNT_W'(1));
         miss_ff   <= (kind == KIND_MISS) ? sat_add(miss_ff, CNT_W'(1)) : miss_ff;
         time_ff   <= sat_add(time_ff, cost);
      end
   end

   assign rsp.hit_kind     = kind_ff;
   assign rsp.access_total = access_ff;
   assign rsp.miss_total   = miss_ff;
   assign rsp.time_total   = time_ff;

   `DMCSB_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1,
      fill_ff <= FW'(D), "side buffer fill above its depth")
   `DMCSB_ASSERT_NEXT(a_access_nonzero, clock, reset, cmd.update,
      access_ff != '0, "access count wrapped to zero")
   `DMCSB_ASSERT_NEXT(a_hit_keeps_fill, clock, reset, cmd.update && line_hit,
      $stable(fill_ff), "side buffer changed on a line hit")

endmodule

/* rtl/core/direct_mapped_cache_with_side_buffer.sv */
// ----------------------------------------------------------------------------
// direct_mapped_cache_with_side_buffer
// Tag-side model of a direct-mapped cache with a victim or stream side buffer.
//
// Each address accepted on the req_ channel yields one item on the rsp_
// channel with the hit kind and the saturating access, miss and time totals.
// With a power-of-two LINE_COUNT an address goes through a tag memory read,
// then compare and write-back on the same memory; the next address is taken
// in the compare step once the result can be presented, so a result stall
// holds the flow. Other line counts add low and high reciprocal-multiply
// steps for the index reduction before the read. After reset the tag store
// is swept clear, during which req_tready stays low; configuration writes
// are taken at any time but should be made only while no item is in flight.
// ----------------------------------------------------------------------------
module direct_mapped_cache_with_side_buffer #(
   parameter int LINE_COUNT    = 1024,
   parameter int BUFFER_DEPTH  = 6,
   parameter int ADDRESS_WIDTH = 32,
   localparam int REQ_TDATA_W  = ((ADDRESS_WIDTH + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // address
   input  logic [REQ_TDATA_W-1:0]              req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // hit_kind, access_total, miss_total, time_total
   output logic [dmcsb_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dmcsb_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [dmcsb_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [dmcsb_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                                csr_pready
);

   import dmcsb_pkg::*;

   cmd_type cmd;
   sts_type sts;
   rsp_type rsp;

   assign csr_pready = 1'b1;
   assign rsp_tdata  = RSP_TDATA_W'(rsp);

   dmcsb_ctrl #(
      .SHORT_INDEX (is_pow2(LINE_COUNT))
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   dmcsb_dp #(
      .LINE_COUNT    (LINE_COUNT),
      .BUFFER_DEPTH  (BUFFER_DEPTH),
      .ADDRESS_WIDTH (ADDRESS_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .address     (req_tdata[ADDRESS_WIDTH-1:0]),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .rsp         (rsp)
   );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for direct_mapped_cache_with_side_buffer
// Addresses are streamed into the cache model under a series of register
// settings covering every mode, the smallest block and cache sizes, and
// blocks larger than the cache. A scoreboard class keeps its own copy of the
// tag store, the side buffer and the counters, predicts each result and
// compares it field by field. Both channels idle at random, with one
// full-speed stretch and one long result stall that backs the block up.
// ----------------------------------------------------------------------------
import dmcsb_pkg::*;

class hit_tracker;
   localparam int LINES = 1024;
   localparam int SIDE_DEPTH = 6;
   localparam logic [31:0] COST_LINE = 32'd1;
   localparam logic [31:0] COST_SIDE = 32'd6;
   localparam logic [31:0] COST_MISS = 32'd100;

   logic [1:0]  mode;
   logic [3:0]  bsl;
   logic [4:0]  csl;
   logic [31:0] line_tag [LINES];
   bit          line_valid [LINES];
   logic [31:0] side_buf [$];
   logic [31:0] access_cnt;
   logic [31:0] miss_cnt;
   logic [31:0] time_cnt;
   rsp_type     pending_rsp [$];
   int          failures;
   int          checked;
   int          kind_seen [4];

   function new();
      mode = MODE_RESET;
      bsl = BSL_RESET;
      csl = CSL_RESET;
      foreach (line_valid[i]) line_valid[i] = 1'b0;
      access_cnt = '0;
      miss_cnt = '0;
      time_cnt = '0;
      failures = 0;
      checked = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
   endfunction

   function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
         CSR_MODE: mode = value[1:0];
         CSR_BLOCK: bsl = value[3:0];
         CSR_CACHE: csl = value[4:0];
         default: ;
      endcase
   endfunction

   function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
      logic [31:0] s;
      s = a + b;
      return (s < a) ? 32'hFFFF_FFFF : s;
   endfunction

   function bit side_take(logic [31:0] blk);
      for (int i = 0; i < side_buf.size(); i++) begin
         if (side_buf[i] == blk) begin
            side_buf.delete(i);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function void side_push(logic [31:0] value);
      if (side_buf.size() >= SIDE_DEPTH) void'(side_buf.pop_front());
      side_buf.push_back(value);
   endfunction

   function void note_address(logic [31:0] addr);
      logic [31:0] blk;
      logic [63:0] cmask;
      int unsigned idx;
      logic [1:0]  kind;
      logic [31:0] victim;
      bit          had;
      rsp_type     want;
      blk = addr >> bsl;
      cmask = (64'd1 << csl) - 64'd1;
      idx = int'(((64'(addr) & cmask) >> bsl) % LINES);
      access_cnt = sat_sum(access_cnt, 32'd1);
      if (line_valid[idx] && line_tag[idx] == blk) begin
         kind = KIND_LINE;
      end else if (mode == MODE_VICTIM) begin
         had = line_valid[idx];
         victim = line_tag[idx];
         kind = side_take(blk) ? KIND_BUFFER : KIND_MISS;
         line_tag[idx] = blk;
         line_valid[idx] = 1'b1;
         if (had) side_push(victim);
      end else if (mode == MODE_STREAM) begin
         line_tag[idx] = blk;
         line_valid[idx] = 1'b1;
         kind = side_take(blk) ? KIND_BUFFER : KIND_MISS;
         side_push(blk + 32'd1);
      end else begin
         kind = KIND_MISS;
         line_tag[idx] = blk;
         line_valid[idx] = 1'b1;
      end
      case (kind)
         KIND_LINE: time_cnt = sat_sum(time_cnt, COST_LINE);
         KIND_BUFFER: time_cnt = sat_sum(time_cnt, COST_SIDE);
         default: begin
            miss_cnt = sat_sum(miss_cnt, 32'd1);
            time_cnt = sat_sum(time_cnt, COST_MISS);
         end
      endcase
      want.hit_kind = kind;
      want.access_total = access_cnt;
      want.miss_total = miss_cnt;
      want.time_total = time_cnt;
      pending_rsp.push_back(want);
   endfunction

   function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
      end
   endfunction

   function void check_response(logic [RSP_TDATA_W-1:0] data);
      rsp_type got;
      rsp_type want;
      got = data[RSP_BITS-1:0];
      if (pending_rsp.size() == 0) begin
         failures++;
         $display("%0t ns: result with nothing expected, expected none, got kind %0d",
                  $time, got.hit_kind);
         return;
      end
      want = pending_rsp.pop_front();
      checked++;
      kind_seen[want.hit_kind]++;
      compare_field("hit_kind", 32'(want.hit_kind), 32'(got.hit_kind));
      compare_field("access_total", want.access_total, got.access_total);
      compare_field("miss_total", want.miss_total, got.miss_total);
      compare_field("time_total", want.time_total, got.time_total);
   endfunction
endclass

module tb_top;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 190;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int IDLE_PCT = 36;

   logic                   clock;
   logic                   reset = 1'b1;
   logic [31:0]            req_tdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]      csr_paddr = '0;
   logic [CSR_DW-1:0]      csr_pwdata = '0;
   logic [CSR_DW-1:0]      csr_prdata;
   logic                   csr_pready;

   hit_tracker  sb = new();
   int          idle_pct = IDLE_PCT;
   int          hold_request = 0;
   int          hold_left = 0;
   int          cycle_count = 0;
   int          settings_used = 1;
   logic [31:0] recent [$];
   logic [31:0] stream_at = '0;

   direct_mapped_cache_with_side_buffer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),    // address
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),    // hit_kind, access_total, miss_total, time_total
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("direct_mapped_cache_with_side_buffer test failed");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (hold_request != 0) begin
            hold_left = HOLD_CYCLES;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   task automatic send_address(logic [31:0] addr);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= addr;
      do @(posedge clock); while (!req_tready);
      sb.note_address(addr);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_register(idx, value);
   endtask

   task automatic apply_setting(logic [1:0] m, logic [3:0] b, logic [4:0] c);
      csr_write(CSR_MODE, 32'(m));
      csr_write(CSR_BLOCK, 32'(b));
      csr_write(CSR_CACHE, 32'(c));
      settings_used++;
   endtask

   // Mostly reuse, same-line conflicts and sequential streams, so that line and
   // buffer hits are frequent; the remainder is fully random noise.
   function automatic logic [31:0] pick_address();
      logic [31:0] a;
      logic [31:0] offset_mask;
      int unsigned r;
      offset_mask = (32'd1 << sb.bsl) - 32'd1;
      r = $urandom_range(99);
      if (r < 30 && recent.size() > 0) begin
         a = recent[$urandom_range(recent.size() - 1)] ^ ($urandom() & offset_mask);
      end else if (r < 55) begin
         a = (32'($urandom_range(7)) << sb.csl) + (32'($urandom_range(3)) << sb.bsl)
             + ($urandom() & offset_mask);
      end else if (r < 80) begin
         if ($urandom_range(15) == 0)
            stream_at = $urandom_range(1) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(255);
         else
            stream_at = stream_at + (32'd1 << sb.bsl);
         a = stream_at;
      end else begin
         a = $urandom();
      end
      recent.push_back(a);
      if (recent.size() > 12) void'(recent.pop_front());
      return a;
   endfunction

   initial begin
      logic [31:0] plain_seq [6] = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     32'h8000, 32'h0};
      logic [31:0] stream_seq [3] = '{32'hFFFF_FFFF, 32'h0, 32'h1};
      logic [31:0] spare_seq [3] = '{32'h0012_3456, 32'h0012_3456, 32'h0052_3456};
      logic [1:0]  phase_mode [PHASES] = '{MODE_VICTIM, MODE_STREAM, MODE_PLAIN,
                                           MODE_VICTIM, MODE_STREAM, MODE_VICTIM,
                                           MODE_SPARE, MODE_STREAM, MODE_VICTIM,
                                           MODE_PLAIN};
      logic [3:0]  phase_bsl [PHASES] = '{4'd5, 4'd3, 4'd0, 4'd12, 4'd0, 4'd2, 4'd6,
                                          4'd12, 4'd0, 4'd8};
      logic [4:0]  phase_csl [PHASES] = '{5'd10, 5'd8, 5'd4, 5'd22, 5'd0, 5'd22, 5'd12,
                                          5'd14, 5'd5, 5'd20};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Registers at their reset values: plain direct-mapped lookups.
      foreach (plain_seq[i]) send_address(plain_seq[i]);
      drain_results();

      // Victim buffer: swap back on a buffer hit, then overflow the buffer.
      apply_setting(MODE_VICTIM, 4'd5, 5'd15);
      send_address(32'h8000);
      send_address(32'h0);
      send_address(32'h8000);
      for (int k = 2; k <= 9; k++) send_address(32'h8000 * k);
      send_address(32'h1_0000);
      drain_results();

      // Stream buffer with unit blocks: the next block wraps to zero.
      apply_setting(MODE_STREAM, 4'd0, 5'd0);
      foreach (stream_seq[i]) send_address(stream_seq[i]);
      drain_results();

      // Unused mode code with blocks larger than the cache.
      apply_setting(MODE_SPARE, 4'd12, 5'd3);
      foreach (spare_seq[i]) send_address(spare_seq[i]);
      drain_results();

      for (int p = 0; p < PHASES; p++) begin
         apply_setting(phase_mode[p], phase_bsl[p], phase_csl[p]);
         stream_at = $urandom();
         recent.delete();
         idle_pct = (p == 5) ? 0 : IDLE_PCT;
         if (p == 3) hold_request = 1;
         for (int n = 0; n < PHASE_ITEMS; n++) send_address(pick_address());
         drain_results();
      end
      idle_pct = IDLE_PCT;
      repeat (20) @(posedge clock);

      $display("Checked %0d results over %0d register settings in all four mode codes.",
               sb.checked, settings_used);
      $display("Outcomes: %0d misses, %0d line hits, %0d side buffer hits.",
               sb.kind_seen[KIND_MISS], sb.kind_seen[KIND_LINE], sb.kind_seen[KIND_BUFFER]);
      if (sb.pending_rsp.size() != 0)
         $display("%0t ns: results outstanding expected 0, got %0d", $time,
                  sb.pending_rsp.size());
      if (sb.failures == 0 && sb.pending_rsp.size() == 0) begin
         $display("direct_mapped_cache_with_side_buffer test passed");
      end else begin
         $display("direct_mapped_cache_with_side_buffer test failed");
      end
      $finish;
   end
endmodule
